### rtl/pmf_pkg.sv
// pmf_pkg: shared types and constants of the probability remap box mean filter
// no dependencies; used by the top level prob_remap_box_mean_filter
package pmf_pkg;

    // probability one in unsigned q1.16
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // coordinate width set by the 11-bit size registers
    localparam int unsigned CW = 11;

    // command code of a drain word
    localparam logic CMD_DRAIN = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_WINDOW_RADIUS = 3'd2,
        REG_MAP_MIN       = 3'd3,
        REG_MAP_MAX       = 3'd4
    } t_reg_idx;

endpackage

### rtl/pmf_div.sv
// pmf_div: serial restoring divider, one quotient bit per cycle
// signed dividend over unsigned divisor, truncating toward zero; no dependencies
module pmf_div #(
    parameter int NW = 41,
    parameter int DW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_dividend,
    input  logic        [DW-1:0] i_divisor,
    output logic                 o_done,
    output logic        [31:0]   o_quotient
);

    localparam int CNW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [CNW-1:0] r_cnt;

    logic [NW-1:0] mag;
    logic [DW:0]   sh;
    logic [DW:0]   sh_sub;
    logic          qbit;

    // magnitude of the dividend
    assign mag = i_dividend[NW-1] ? NW'(-i_dividend) : NW'(i_dividend);

    // one restoring step
    always_comb begin
        sh     = {r_rem, r_quo[NW-1]};
        sh_sub = sh - {1'b0, r_div};
        qbit   = (sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[NW-1];
            r_quo <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], qbit};
            r_rem <= qbit ? sh_sub[DW-1:0] : sh[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo[31:0]) : r_quo[31:0];

endmodule

### rtl/prob_remap_box_mean_filter.sv
// prob_remap_box_mean_filter: maps probability cells to costs, then box mean over a window (R >= 2)
// depends on pmf_pkg and pmf_div
//
//  channel | direction | signals                                   | word
//  input   | in        | i_in_valid, o_in_ready, i_cmd, i_cell_prob | one cell or drain beat
//  output  | out       | o_out_valid, i_out_ready, o_filtered_value,| one filtered cell
//          |           | o_last_of_frame                           |
//  config  | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready | apb register
//
// a cell word is taken, then mapped, stored and set up (S_MAP, S_WRITE, S_POST); for an output
// with R >= 2 the window is then read one cell per cycle from the single read port ((2R+1)^2
// cells at most, fewer at the grid border), then drained and divided in the serial divider.
// for passthrough (R < 2) outputs the cell is read in S_POST, registered in S_PRD and offered
// in S_OUT. one word is in flight at a time and o_in_ready stays low until
// its result, if any, is taken. reset is synchronous and active low;
// the line store is not cleared, every read hits a cell written earlier in the frame.
module prob_remap_box_mean_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [16:0] i_cell_prob,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_filtered_value,
    output logic        o_last_of_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import pmf_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int SROWS = 2 * MAX_RADIUS + 2;
    localparam int SW    = $clog2(SROWS);
    localparam int AW    = SW + XW;
    localparam int CNTW  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUMW  = 32 + CNTW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MAP   = 10'b0000000010,
        S_WRITE = 10'b0000000100,
        S_POST  = 10'b0000001000,
        S_PRD   = 10'b0000010000,
        S_SCAN  = 10'b0000100000,
        S_DRAIN = 10'b0001000000,
        S_DIVS  = 10'b0010000000,
        S_DIVW  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // configuration registers
    logic [10:0]        r_frame_width;
    logic [10:0]        r_frame_height;
    logic [3:0]         r_window_radius;
    logic signed [31:0] r_map_min;
    logic signed [31:0] r_map_max;

    // control state
    t_state          r_state;
    logic [CW-1:0]   r_col, r_row;
    logic [SW-1:0]   r_wslot;
    logic [CW-1:0]   r_ox, r_oy;
    logic [SW-1:0]   r_oslot;
    logic [22:0]     r_k;
    logic            r_wr;
    logic            r_do_out;
    logic            r_last;
    logic            r_acc_v;
    logic            r_out_valid;

    // payload
    logic [16:0]        r_inv;
    logic signed [50:0] r_prod;
    logic [CW-1:0]      r_sx, r_sy, r_xlo, r_xhi, r_yhi;
    logic [SW-1:0]      r_sslot;
    logic [CNTW-1:0]    r_cnt;
    logic signed [SUMW-1:0] r_sum;
    logic signed [31:0] r_rdata;
    logic [31:0]        r_out_val;

    logic signed [31:0] mem [0:(1 << AW) - 1];

    // effective sizes
    logic [10:0] eff_w, eff_h;
    logic [4:0]  eff_r;
    logic [21:0] total;
    logic [16:0] lat;

    always_comb begin
        if (r_frame_width == 11'd0)                          eff_w = 11'd1;
        else if ({2'b0, r_frame_width} > 13'(MAX_WIDTH))     eff_w = 11'(MAX_WIDTH);
        else                                                 eff_w = r_frame_width;
        if (r_frame_height == 11'd0)                         eff_h = 11'd1;
        else if ({2'b0, r_frame_height} > 13'(MAX_HEIGHT))   eff_h = 11'(MAX_HEIGHT);
        else                                                 eff_h = r_frame_height;
        if ({1'b0, r_window_radius} > 5'(MAX_RADIUS))        eff_r = 5'(MAX_RADIUS);
        else                                                 eff_r = {1'b0, r_window_radius};
    end

    assign total = 22'(eff_w) * 22'(eff_h);
    assign lat   = 17'(eff_r) * 17'(eff_w) + 17'(eff_r);

    // accept side decisions
    logic        pix_phase;
    logic [22:0] out_idx;
    logic [16:0] prob_sat;

    assign pix_phase = r_k < 23'(total);
    assign out_idx   = r_k - 23'(lat);
    assign prob_sat  = (i_cell_prob > ONE_Q16) ? ONE_Q16 : i_cell_prob;

    // mapping: product, rounding toward zero, offset and saturation
    logic signed [32:0] map_range;
    logic signed [50:0] map_prod, map_bias, map_q, map_v;
    logic signed [31:0] map_val;

    always_comb begin
        map_range = 33'(r_map_max) - 33'(r_map_min);
        map_prod  = $signed({1'b0, r_inv}) * map_range;
        map_bias  = r_prod[50] ? 51'sd65535 : 51'sd0;
        map_q     = (r_prod + map_bias) >>> 16;
        map_v     = map_q + 51'(r_map_min);
        if (map_v > 51'sd2147483647)       map_val = 32'sh7fffffff;
        else if (map_v < -51'sd2147483648) map_val = 32'sh80000000;
        else                               map_val = map_v[31:0];
    end

    // window bounds of the current output cell
    logic [CW-1:0] dxl, dyl, xlo_c, ylo_c, xhi_c, yhi_c;
    logic [CW:0]   xr_c, yr_c;
    logic signed [6:0] slot_t;
    logic [SW-1:0] slot_lo;

    always_comb begin
        dxl   = (r_ox < CW'(eff_r)) ? r_ox : CW'(eff_r);
        dyl   = (r_oy < CW'(eff_r)) ? r_oy : CW'(eff_r);
        xlo_c = r_ox - dxl;
        ylo_c = r_oy - dyl;
        xr_c  = {1'b0, r_ox} + 12'(eff_r);
        yr_c  = {1'b0, r_oy} + 12'(eff_r);
        xhi_c = (xr_c >= {1'b0, eff_w}) ? (eff_w - 11'd1) : xr_c[CW-1:0];
        yhi_c = (yr_c >= {1'b0, eff_h}) ? (eff_h - 11'd1) : yr_c[CW-1:0];
        slot_t = 7'(r_oslot) - 7'(dyl[4:0]);
        if (slot_t < 0) slot_t = slot_t + 7'(SROWS);
        slot_lo = slot_t[SW-1:0];
    end

    // memory port control
    logic          wr_en, rd_en;
    logic [AW-1:0] waddr, raddr;
    logic [11:0]   wx12, rx12;

    always_comb begin
        wr_en = (r_state == S_WRITE);
        wx12  = {1'b0, r_col};
        waddr = {r_wslot, wx12[XW-1:0]};
        rd_en = 1'b0;
        rx12  = {1'b0, r_sx};
        raddr = {r_sslot, rx12[XW-1:0]};
        if (r_state == S_SCAN) begin
            rd_en = 1'b1;
        end else if (r_state == S_POST && r_do_out && eff_r < 5'd2) begin
            rd_en = 1'b1;
            rx12  = {1'b0, r_ox};
            raddr = {r_oslot, rx12[XW-1:0]};
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= map_val;
        end
        if (rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    // divider
    logic        div_done;
    logic [31:0] div_quo;

    pmf_div #(
        .NW(SUMW),
        .DW(CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVS),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // apb write
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    // apb read
    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_FRAME_WIDTH:   prdata = {21'd0, r_frame_width};
            REG_FRAME_HEIGHT:  prdata = {21'd0, r_frame_height};
            REG_WINDOW_RADIUS: prdata = {28'd0, r_window_radius};
            REG_MAP_MIN:       prdata = r_map_min;
            REG_MAP_MAX:       prdata = r_map_max;
            default:           prdata = 32'd0;
        endcase
    end

    logic cfg_hit;
    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_WINDOW_RADIUS,
            REG_MAP_MIN, REG_MAP_MAX: cfg_hit = 1'b1;
            default:                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 11'd1024;
            r_frame_height  <= 11'd1024;
            r_window_radius <= 4'd0;
            r_map_min       <= 32'sd0;
            r_map_max       <= 32'sd65536;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_FRAME_WIDTH:   r_frame_width   <= pwdata[10:0];
                REG_FRAME_HEIGHT:  r_frame_height  <= pwdata[10:0];
                REG_WINDOW_RADIUS: r_window_radius <= pwdata[3:0];
                REG_MAP_MIN:       r_map_min       <= pwdata;
                REG_MAP_MAX:       r_map_max       <= pwdata;
                default: ;
            endcase
        end
    end

    // end of word bookkeeping
    logic        restart;
    logic [22:0] k_next;
    assign k_next  = r_k + 23'd1;
    assign restart = (r_do_out && r_last) || (k_next >= 23'(total) + 23'(lat));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_wslot     <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_oslot     <= '0;
            r_k         <= '0;
            r_wr        <= 1'b0;
            r_do_out    <= 1'b0;
            r_last      <= 1'b0;
            r_acc_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_v <= (r_state == S_SCAN);
            case (r_state)
                S_IDLE: begin
                    if (cfg_wr && cfg_hit) begin
                        r_col   <= '0;
                        r_row   <= '0;
                        r_wslot <= '0;
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_oslot <= '0;
                        r_k     <= '0;
                    end else if (i_in_valid && !(pix_phase && i_cmd == CMD_DRAIN)) begin
                        r_wr     <= pix_phase;
                        r_inv    <= ONE_Q16 - prob_sat;
                        r_do_out <= (r_k >= 23'(lat)) && (out_idx < 23'(total));
                        r_last   <= out_idx == 23'(total) - 23'd1;
                        r_state  <= pix_phase ? S_MAP : S_POST;
                    end
                end
                S_MAP: begin
                    r_prod  <= map_prod;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    // advance the write position
                    if ({1'b0, r_col} + 12'd1 >= {1'b0, eff_w}) begin
                        r_col   <= '0;
                        r_row   <= r_row + 1'b1;
                        r_wslot <= (r_wslot == SW'(SROWS - 1)) ? '0 : r_wslot + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_xlo   <= xlo_c;
                    r_xhi   <= xhi_c;
                    r_yhi   <= yhi_c;
                    r_sx    <= xlo_c;
                    r_sy    <= ylo_c;
                    r_sslot <= slot_lo;
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    if (restart) begin
                        r_col   <= '0;
                        r_row   <= '0;
                        r_wslot <= '0;
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_oslot <= '0;
                        r_k     <= '0;
                    end else begin
                        // advance the output position
                        if (r_do_out) begin
                            if ({1'b0, r_ox} + 12'd1 >= {1'b0, eff_w}) begin
                                r_ox    <= '0;
                                r_oy    <= r_oy + 1'b1;
                                r_oslot <= (r_oslot == SW'(SROWS - 1)) ? '0 : r_oslot + 1'b1;
                            end else begin
                                r_ox <= r_ox + 1'b1;
                            end
                        end
                        r_k <= k_next;
                    end
                    if (!r_do_out)         r_state <= S_IDLE;
                    else if (eff_r < 5'd2) r_state <= S_PRD;
                    else                   r_state <= S_SCAN;
                end
                S_PRD: begin
                    r_out_val   <= r_rdata;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_sx == r_xhi) begin
                        r_sx <= r_xlo;
                        if (r_sy == r_yhi) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_sy    <= r_sy + 1'b1;
                            r_sslot <= (r_sslot == SW'(SROWS - 1)) ? '0 : r_sslot + 1'b1;
                        end
                    end else begin
                        r_sx <= r_sx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_out_val   <= div_quo;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // window accumulation, in the cycle after the read
            if (r_acc_v) begin
                r_sum <= r_sum + SUMW'(r_rdata);
            end
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_val;
    assign o_last_of_frame  = r_last;

    // checks
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVS) |-> (r_cnt != '0))
        else $error("mean started with an empty window");

    a_write_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_col < eff_w) && r_wr)
        else $error("store write outside the pixel phase");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_sx <= r_xhi) && (r_sy <= r_yhi))
        else $error("window scan left its bounds");

    a_out_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("block not idle after a result was taken");

endmodule
